FILE: design/osa_pkg.sv
// Shared types and constants for the overlap susceptibility accumulator.
package osa_pkg;

    localparam int COORD_W   = 24;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int SQ_AXIS_W = 2 * COORD_W;
    localparam int R2_W      = SQ_AXIS_W + 2;

    localparam int OVL_W   = 52;
    localparam int ATOMS_W = 17;
    localparam int FRAMES_W = 13;
    localparam int VOL_W   = 40;
    localparam int DIM_W   = 2;

    localparam int HITS_W  = 17;
    localparam int SUM_W   = 29;
    localparam int SQSUM_W = 45;

    localparam int MEAN_W  = 17;
    localparam int SUS_W   = 48;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Register indexes on the configuration port
    localparam logic [2:0] REG_OVERLAP_SQ = 3'd0;
    localparam logic [2:0] REG_ATOM_COUNT = 3'd1;
    localparam logic [2:0] REG_FRAMES     = 3'd2;
    localparam logic [2:0] REG_VOLUME     = 3'd3;
    localparam logic [2:0] REG_DIMENSIONS = 3'd4;

    // Classified atom passed from front to back
    typedef struct packed {
        logic hit;
        logic frame_end;
        logic lag_end;
    } osa_item_t;

endpackage

FILE: design/overlap_susceptibility_accumulator.sv
// Top level: configuration registers, front end, queue and back end.
//
// Atoms stream in one per transfer and are classified at one per cycle, while
// the queue is not full, by a two-stage front pipeline; the back end counts them
// at one per cycle while idle, folds the count into the sums in a close state at
// every frame or lag end, and at a lag end runs four partial products, a 45-step
// mean division and a 106-step susceptibility division in one shared bit-serial
// divider before the result is transferred. A four-entry queue lets the front
// keep accepting while the back end is busy, until the queue fills.
module overlap_susceptibility_accumulator
    import osa_pkg::*;
#(
    parameter int MAX_ATOMS  = 65536,
    parameter int MAX_FRAMES = 4096
)
(
    input  logic         clk,
    input  logic         rst_n,
    // now_x, now_y, now_z, origin_x, origin_y, origin_z
    input  logic [143:0] s_tdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic         s_tlast,
    // lag_end
    input  logic         s_tuser,
    // mean_overlap, susceptibility, overlap_total
    output logic [95:0]  m_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    logic [OVL_W-1:0]    ovl_reg;
    logic [ATOMS_W-1:0]  atoms_reg;
    logic [FRAMES_W-1:0] frames_reg;
    logic [VOL_W-1:0]    volume_reg;
    logic [DIM_W-1:0]    dims_reg;

    logic      q_full, q_push, q_pop, q_valid;
    osa_item_t push_item, pop_item;

    assign pready = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovl_reg    <= OVL_W'(64'd16777216);
            atoms_reg  <= ATOMS_W'(1);
            frames_reg <= FRAMES_W'(1);
            volume_reg <= VOL_W'(256);
            dims_reg   <= DIM_W'(3);
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[5:3])
                REG_OVERLAP_SQ: ovl_reg    <= pwdata[OVL_W-1:0];
                REG_ATOM_COUNT: atoms_reg  <= pwdata[ATOMS_W-1:0];
                REG_FRAMES:     frames_reg <= pwdata[FRAMES_W-1:0];
                REG_VOLUME:     volume_reg <= pwdata[VOL_W-1:0];
                REG_DIMENSIONS: dims_reg   <= pwdata[DIM_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Read back configuration registers
    always_comb
    begin
        unique case (paddr[5:3])
            REG_OVERLAP_SQ: prdata = 64'(ovl_reg);
            REG_ATOM_COUNT: prdata = 64'(atoms_reg);
            REG_FRAMES:     prdata = 64'(frames_reg);
            REG_VOLUME:     prdata = 64'(volume_reg);
            REG_DIMENSIONS: prdata = 64'(dims_reg);
            default:        prdata = '0;
        endcase
    end

    osa_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .dims     (dims_reg),
        .ovl      (ovl_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    osa_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_item  (pop_item)
    );

    osa_back #(
        .MAX_ATOMS  (MAX_ATOMS),
        .MAX_FRAMES (MAX_FRAMES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (pop_item),
        .q_pop    (q_pop),
        .atoms    (atoms_reg),
        .frames   (frames_reg),
        .volume   (volume_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: design/osa_front.sv
// Front end: accepts atoms, forms squared displacement, classifies overlap.
module osa_front
    import osa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [143:0]        s_tdata,
    input  logic                s_tlast,
    input  logic                s_tuser,
    input  logic [DIM_W-1:0]    dims,
    input  logic [OVL_W-1:0]    ovl,
    input  logic                q_full,
    output logic                q_push,
    output osa_item_t           q_item
);

    logic                     advance;
    logic                     v1_reg, v2_reg;
    logic signed [DIFF_W-1:0] d_reg [3];
    logic [SQ_AXIS_W-1:0]     sq_reg [3];
    logic                     fe1_reg, le1_reg, fe2_reg, le2_reg;
    logic [R2_W-1:0]          r2;

    assign advance  = !v2_reg || !q_full;
    assign s_tready = advance;

    // Advance the valid bits of both stages together
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
        end
    end

    // Stage 1: per-axis difference, dropped axes forced to zero
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (dims > DIM_W'(k))
                    d_reg[k] <= DIFF_W'($signed(s_tdata[k*COORD_W +: COORD_W]))
                              - DIFF_W'($signed(s_tdata[(k+3)*COORD_W +: COORD_W]));
                else
                    d_reg[k] <= '0;
            end
            fe1_reg <= s_tlast;
            le1_reg <= s_tuser;
        end
    end

    // Stage 2: square each axis
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < 3; k++)
                sq_reg[k] <= SQ_AXIS_W'(d_reg[k] * d_reg[k]);
            fe2_reg <= fe1_reg;
            le2_reg <= le1_reg;
        end
    end

    // Sum and compare against the overlap length, then transfer to the queue
    assign r2 = R2_W'(sq_reg[0]) + R2_W'(sq_reg[1]) + R2_W'(sq_reg[2]);

    assign q_push           = v2_reg && !q_full;
    assign q_item.hit       = OVL_W'(r2) <= ovl;
    assign q_item.frame_end = fe2_reg;
    assign q_item.lag_end   = le2_reg;

endmodule

FILE: design/osa_queue.sv
// Short queue of classified atoms between front and back.
module osa_queue
    import osa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  osa_item_t push_item,
    output logic      full,
    input  logic      pop,
    output logic      not_empty,
    output osa_item_t pop_item
);

    osa_item_t         mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, rd_reg;
    logic [QPTR_W:0]   cnt_reg;

    assign full      = cnt_reg == (QPTR_W+1)'(QUEUE_DEPTH);
    assign not_empty = cnt_reg != '0;
    assign pop_item  = mem_reg[rd_reg];

    // Move pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_item;
    end

endmodule

FILE: design/osa_back.sv
// Back end: frame counting, running sums and the end-of-lag arithmetic.
module osa_back
    import osa_pkg::*;
#(
    parameter int MAX_ATOMS  = 65536,
    parameter int MAX_FRAMES = 4096
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  osa_item_t           q_item,
    output logic                q_pop,
    input  logic [ATOMS_W-1:0]  atoms,
    input  logic [FRAMES_W-1:0] frames,
    input  logic [VOL_W-1:0]    volume,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [95:0]         m_tdata
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CLOSE = 4'd1;
    localparam logic [3:0] ST_MUL1  = 4'd2;
    localparam logic [3:0] ST_MUL2  = 4'd3;
    localparam logic [3:0] ST_SUBT  = 4'd4;
    localparam logic [3:0] ST_PROD  = 4'd5;
    localparam logic [3:0] ST_DIVM  = 4'd6;
    localparam logic [3:0] ST_DIVS  = 4'd7;
    localparam logic [3:0] ST_DONE  = 4'd8;

    localparam int NF_W   = ATOMS_W + FRAMES_W;
    localparam int NF2_W  = 2 * NF_W;
    localparam int A_W    = SQSUM_W + FRAMES_W;
    localparam int VS_W   = VOL_W + 8;
    localparam int PROD_W = A_W + VS_W;
    localparam int NH_W   = A_W / 2;
    localparam int VH_W   = VS_W / 2;
    localparam int PP_W   = NH_W + VH_W;
    localparam int REM_W  = NF2_W + 1;
    localparam int CNT_W  = $clog2(PROD_W + 1);
    localparam int MEAN_DVD_W = SUM_W + 16;

    logic [3:0]          state_reg;
    logic [HITS_W-1:0]   fh_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SQSUM_W-1:0]  sq_reg;
    logic                lag_reg;
    logic [NF_W-1:0]     nf_reg;
    logic [NF2_W-1:0]    nf2_reg;
    logic [A_W-1:0]      a_reg, b_reg, num_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [1:0]          pcnt_reg;
    logic [PROD_W-1:0]   dvd_reg;
    logic [NF2_W-1:0]    den_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [SUS_W-1:0]    quo_reg;
    logic                sat_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [MEAN_W-1:0]   mean_reg;
    logic                out_valid_reg;
    logic [95:0]         out_data_reg;

    logic [ATOMS_W-1:0]  n_use;
    logic [FRAMES_W-1:0] f_use;
    logic [SUM_W:0]      sum_add;
    logic [SQSUM_W:0]    sq_add;
    logic [NH_W-1:0]     n_half;
    logic [VH_W-1:0]     v_half;
    logic [PP_W-1:0]     pp;
    logic [PROD_W-1:0]   pp_shift;
    logic [VS_W-1:0]     vs;
    logic [REM_W-1:0]    rem_sh;
    logic                ge;
    logic [SUS_W-1:0]    quo_final;
    logic                out_load;

    // Clamp the normalization counts
    always_comb
    begin
        if (atoms == '0)
            n_use = ATOMS_W'(1);
        else if (int'(atoms) > MAX_ATOMS)
            n_use = ATOMS_W'(MAX_ATOMS);
        else
            n_use = atoms;
        if (frames == '0)
            f_use = FRAMES_W'(1);
        else if (int'(frames) > MAX_FRAMES)
            f_use = FRAMES_W'(MAX_FRAMES);
        else
            f_use = frames;
    end

    assign sum_add = (SUM_W+1)'(sum_reg) + (SUM_W+1)'(fh_reg);
    assign sq_add  = (SQSUM_W+1)'(sq_reg) + (SQSUM_W+1)'(fh_reg * fh_reg);

    // Partial product of the variance numerator and the scaled volume
    assign vs     = {volume, 8'b0};
    assign n_half = pcnt_reg[1] ? num_reg[A_W-1 -: NH_W] : num_reg[NH_W-1:0];
    assign v_half = pcnt_reg[0] ? vs[VS_W-1 -: VH_W] : vs[VH_W-1:0];
    assign pp     = PP_W'(n_half * v_half);

    always_comb
    begin
        case (pcnt_reg)
            2'd0:    pp_shift = PROD_W'(pp);
            2'd1:    pp_shift = PROD_W'(pp) << VH_W;
            2'd2:    pp_shift = PROD_W'(pp) << NH_W;
            default: pp_shift = PROD_W'(pp) << (NH_W + VH_W);
        endcase
    end

    // One restoring division step
    assign rem_sh    = {rem_reg[REM_W-2:0], dvd_reg[PROD_W-1]};
    assign ge        = rem_sh >= REM_W'(den_reg);
    assign quo_final = sat_reg ? '1 : quo_reg;

    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Sequence frame closing and the end-of-lag arithmetic
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fh_reg        <= '0;
            sum_reg       <= '0;
            sq_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        if (q_item.hit && fh_reg != '1)
                            fh_reg <= fh_reg + 1'b1;
                        if (q_item.frame_end || q_item.lag_end)
                            state_reg <= ST_CLOSE;
                    end
                end
                ST_CLOSE:
                begin
                    sum_reg   <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
                    sq_reg    <= sq_add[SQSUM_W] ? '1 : sq_add[SQSUM_W-1:0];
                    fh_reg    <= '0;
                    state_reg <= lag_reg ? ST_MUL1 : ST_IDLE;
                end
                ST_MUL1: state_reg <= ST_MUL2;
                ST_MUL2: state_reg <= ST_SUBT;
                ST_SUBT: state_reg <= ST_PROD;
                ST_PROD:
                begin
                    if (pcnt_reg == 2'd3)
                        state_reg <= ST_DIVM;
                end
                ST_DIVM:
                begin
                    if (cnt_reg == CNT_W'(1))
                        state_reg <= ST_DIVS;
                end
                ST_DIVS:
                begin
                    if (cnt_reg == CNT_W'(1))
                        state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_load)
                    begin
                        out_valid_reg <= 1'b1;
                        sum_reg       <= '0;
                        sq_reg        <= '0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers of the arithmetic sequence
    always_ff @(posedge clk)
    begin
        case (state_reg) inside
            ST_IDLE:
            begin
                lag_reg <= q_item.lag_end;
            end
            ST_MUL1:
            begin
                nf_reg <= NF_W'(n_use * f_use);
                a_reg  <= A_W'(sq_reg * f_use);
            end
            ST_MUL2:
            begin
                b_reg   <= A_W'(sum_reg * sum_reg);
                nf2_reg <= NF2_W'(nf_reg * nf_reg);
            end
            ST_SUBT:
            begin
                num_reg  <= (a_reg > b_reg) ? a_reg - b_reg : '0;
                prod_reg <= '0;
                pcnt_reg <= 2'd0;
            end
            ST_PROD:
            begin
                prod_reg <= prod_reg + pp_shift;
                pcnt_reg <= pcnt_reg + 1'b1;
                if (pcnt_reg == 2'd3)
                begin
                    dvd_reg <= {sum_reg, 16'b0, (PROD_W - MEAN_DVD_W)'(0)};
                    den_reg <= NF2_W'(nf_reg);
                    rem_reg <= '0;
                    quo_reg <= '0;
                    sat_reg <= 1'b0;
                    cnt_reg <= CNT_W'(MEAN_DVD_W);
                end
            end
            ST_DIVM, ST_DIVS:
            begin
                rem_reg <= ge ? rem_sh - REM_W'(den_reg) : rem_sh;
                dvd_reg <= dvd_reg << 1;
                quo_reg <= {quo_reg[SUS_W-2:0], ge};
                if (quo_reg[SUS_W-1])
                    sat_reg <= 1'b1;
                cnt_reg <= cnt_reg - 1'b1;
                if (state_reg == ST_DIVM && cnt_reg == CNT_W'(1))
                begin
                    if (quo_reg[SUS_W-1] || sat_reg
                        || {quo_reg[SUS_W-2:0], ge} > SUS_W'(65536))
                        mean_reg <= MEAN_W'(65536);
                    else
                        mean_reg <= MEAN_W'({quo_reg[SUS_W-2:0], ge});
                    dvd_reg <= prod_reg;
                    den_reg <= nf2_reg;
                    rem_reg <= '0;
                    quo_reg <= '0;
                    sat_reg <= 1'b0;
                    cnt_reg <= CNT_W'(PROD_W);
                end
            end
            ST_DONE:
            begin
                if (out_load)
                    out_data_reg <= {2'b0, sum_reg, quo_final, mean_reg};
            end
            default:
            begin
            end
        endcase
    end

    // Frame count is empty after every close
    a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLOSE |=> fh_reg == '0)
        else $error("frame count not cleared after close");

    // A pending result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || m_tready))
        else $error("result overwritten while pending");

    // Queue is not drained while the arithmetic runs
    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == ST_IDLE)
        else $error("queue popped while busy");

    // Sums are cleared once a result is loaded
    a_sums_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (sum_reg == '0 && sq_reg == '0))
        else $error("sums not cleared after result");

endmodule

FILE: verif/tb.sv
// Testbench for the overlap susceptibility accumulator: directed and random atom streams.
`timescale 1ns / 1ps

module tb;
    import osa_pkg::*;

    typedef struct packed {
        logic [23:0] origin_z;
        logic [23:0] origin_y;
        logic [23:0] origin_x;
        logic [23:0] now_z;
        logic [23:0] now_y;
        logic [23:0] now_x;
        logic        frame_end;
        logic        lag_end;
    } atom_t;

    typedef struct packed {
        logic [SUM_W-1:0]  total;
        logic [SUS_W-1:0]  sus;
        logic [MEAN_W-1:0] mean;
    } lag_result_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic [143:0] s_tdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic         s_tlast = 1'b0;
    logic         s_tuser = 1'b0;
    logic [95:0]  m_tdata;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [5:0]   paddr = '0;
    logic [63:0]  pwdata = '0;
    logic [63:0]  prdata;
    logic         pready;

    // Shadow copy of the registers and accumulator state
    logic [OVL_W-1:0]    sh_overlap;
    logic [ATOMS_W-1:0]  sh_atoms;
    logic [FRAMES_W-1:0] sh_frames;
    logic [VOL_W-1:0]    sh_volume;
    logic [DIM_W-1:0]    sh_dims;
    logic [HITS_W-1:0]   frame_hits;
    logic [SUM_W-1:0]    hit_sum;
    logic [SQSUM_W-1:0]  hit_sq_sum;

    lag_result_t pending_lags[$];
    int          fail_count = 0;
    bit          quiet = 1'b0;
    bit          no_gaps = 1'b0;
    int          hold_left = 0;
    int          stall_left = 0;

    overlap_susceptibility_accumulator uut (.*);

    always #6 clk = ~clk;

    // Watchdog
    initial
    begin
        #50000000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [49:0] axis_sq(logic [23:0] a, logic [23:0] b);
        logic signed [24:0] d;
        logic [24:0]        m;
        d = $signed({a[23], a}) - $signed({b[23], b});
        m = d[24] ? -d : d;
        return m * m;
    endfunction

    // Count one atom and predict the lag result it closes, if any
    function automatic void tally_atom(atom_t a);
        logic [51:0]  r2;
        logic [29:0]  sum_n;
        logic [45:0]  sq_n;
        logic [33:0]  sq;
        logic [16:0]  n;
        logic [12:0]  f;
        logic [63:0]  nf, mean, pa, pb, num;
        logic [127:0] prod, quo;
        lag_result_t  res;
        r2 = 0;
        if (sh_dims >= 1) r2 += axis_sq(a.now_x, a.origin_x);
        if (sh_dims >= 2) r2 += axis_sq(a.now_y, a.origin_y);
        if (sh_dims >= 3) r2 += axis_sq(a.now_z, a.origin_z);
        if (r2 <= sh_overlap && frame_hits != '1)
            frame_hits++;
        if (a.frame_end || a.lag_end)
        begin
            sq = frame_hits * frame_hits;
            sum_n = hit_sum + frame_hits;
            sq_n = hit_sq_sum + sq;
            hit_sum = sum_n[29] ? '1 : sum_n[28:0];
            hit_sq_sum = sq_n[45] ? '1 : sq_n[44:0];
            frame_hits = 0;
        end
        if (!a.lag_end)
            return;
        n = (sh_atoms == 0) ? 17'd1 : (sh_atoms > 65536 ? 17'd65536 : sh_atoms);
        f = (sh_frames == 0) ? 13'd1 : (sh_frames > 4096 ? 13'd4096 : sh_frames);
        nf = n * f;
        mean = {hit_sum, 16'b0} / nf;
        if (mean > 65536)
            mean = 65536;
        pa = hit_sq_sum * f;
        pb = hit_sum * hit_sum;
        num = (pa > pb) ? pa - pb : 0;
        prod = num * {sh_volume, 8'b0};
        quo = prod / (nf * nf);
        res.mean = mean[16:0];
        res.sus = (quo > 128'hFFFF_FFFF_FFFF) ? '1 : quo[47:0];
        res.total = hit_sum;
        pending_lags.insert(pending_lags.size(), res);
        hit_sum = 0;
        hit_sq_sum = 0;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
        fail_count++;
    endtask

    // Check each result transfer against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_lags.size() == 0)
                report_mismatch("unexpected result", m_tdata[63:0], 0);
            else
            begin
                lag_result_t want;
                lag_result_t got;
                want = pending_lags.pop_front();
                got = m_tdata[93:0];
                if (got.mean !== want.mean)
                    report_mismatch("mean_overlap", got.mean, want.mean);
                if (got.sus !== want.sus)
                    report_mismatch("susceptibility", got.sus, want.sus);
                if (got.total !== want.total)
                    report_mismatch("overlap_total", got.total, want.total);
            end
        end
    end

    // Result-side ready: long hold-off, random stall bursts, or steady
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (quiet)
            m_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 7);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    task automatic send_atom(atom_t a);
        if (!quiet && !no_gaps && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_tdata <= {a.origin_z, a.origin_y, a.origin_x, a.now_z, a.now_y, a.now_x};
        s_tlast <= a.frame_end;
        s_tuser <= a.lag_end;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        tally_atom(a);
    endtask

    // Drop valid and let every result drain plus the back end's longest pass
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_lags.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_OVERLAP_SQ: sh_overlap = val[OVL_W-1:0];
            REG_ATOM_COUNT: sh_atoms = val[ATOMS_W-1:0];
            REG_FRAMES:     sh_frames = val[FRAMES_W-1:0];
            REG_VOLUME:     sh_volume = val[VOL_W-1:0];
            REG_DIMENSIONS: sh_dims = val[DIM_W-1:0];
            default: ;
        endcase
    endtask

    function automatic logic [23:0] rand_coord();
        return 24'($urandom());
    endfunction

    // Atom near its origin within span, or fully random now and then
    function automatic atom_t make_atom(int span, bit fe, bit le);
        atom_t a;
        a.origin_x = rand_coord();
        a.origin_y = rand_coord();
        a.origin_z = rand_coord();
        if ($urandom_range(0, 9) == 0)
        begin
            a.now_x = rand_coord();
            a.now_y = rand_coord();
            a.now_z = rand_coord();
        end
        else
        begin
            a.now_x = 24'(a.origin_x + $urandom_range(0, 2 * span) - span);
            a.now_y = 24'(a.origin_y + $urandom_range(0, 2 * span) - span);
            a.now_z = 24'(a.origin_z + $urandom_range(0, 2 * span) - span);
        end
        a.frame_end = fe;
        a.lag_end = le;
        return a;
    endfunction

    function automatic atom_t fixed_atom(logic [23:0] nx, logic [23:0] ox, bit fe, bit le);
        atom_t a;
        a = '0;
        a.now_x = nx;
        a.origin_x = ox;
        a.frame_end = fe;
        a.lag_end = le;
        return a;
    endfunction

    // One lag of one or more frames; the frame marker is sometimes left off
    task automatic run_lag(int frames, int atoms_max, int span);
        int na;
        bit fe;
        for (int fr = 0; fr < frames; fr++)
        begin
            na = $urandom_range(1, atoms_max);
            for (int i = 0; i < na; i++)
            begin
                fe = (i == na - 1) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0);
                send_atom(make_atom(span, fe, (fr == frames - 1) && (i == na - 1)));
            end
        end
    endtask

    task automatic test_reset_defaults();
        atom_t a;
        // zero displacement, exactly one unit, just over one unit
        send_atom(fixed_atom(24'h000100, 24'h000100, 1'b0, 1'b0));
        send_atom(fixed_atom(24'h001000, 24'h000000, 1'b0, 1'b0));
        send_atom(fixed_atom(24'h001001, 24'h000000, 1'b1, 1'b0));
        // extremes on every axis, both directions
        a = '0;
        a.now_x = 24'h7FFFFF; a.now_y = 24'h7FFFFF; a.now_z = 24'h7FFFFF;
        a.origin_x = 24'h800000; a.origin_y = 24'h800000; a.origin_z = 24'h800000;
        send_atom(a);
        a.now_x = 24'h800000; a.now_y = 24'h800000; a.now_z = 24'h800000;
        a.origin_x = 24'h7FFFFF; a.origin_y = 24'h7FFFFF; a.origin_z = 24'h7FFFFF;
        a.frame_end = 1'b1;
        send_atom(a);
        // lag end without a frame end closes the frame
        send_atom(fixed_atom(24'h000000, 24'h000000, 1'b0, 1'b1));
        send_atom(fixed_atom(24'hFFFFFF, 24'h000000, 1'b1, 1'b1));
        wait_idle();
    endtask

    task automatic test_register_extremes();
        // no axes, zero overlap, zero counts, full volume
        write_reg(REG_DIMENSIONS, 0);
        write_reg(REG_OVERLAP_SQ, 0);
        write_reg(REG_ATOM_COUNT, 0);
        write_reg(REG_FRAMES, 0);
        write_reg(REG_VOLUME, 64'hFF_FFFF_FFFF);
        send_atom(fixed_atom(24'h7FFFFF, 24'h800000, 1'b1, 1'b0));
        send_atom(fixed_atom(24'h123456, 24'h000000, 1'b0, 1'b0));
        send_atom(fixed_atom(24'h000000, 24'h000000, 1'b1, 1'b1));
        wait_idle();
        // one axis, full overlap, counts above bound
        write_reg(REG_DIMENSIONS, 1);
        write_reg(REG_OVERLAP_SQ, 64'hF_FFFF_FFFF_FFFF);
        write_reg(REG_ATOM_COUNT, 64'h1FFFF);
        write_reg(REG_FRAMES, 64'h1FFF);
        send_atom(fixed_atom(24'h7FFFFF, 24'h800000, 1'b1, 1'b0));
        send_atom(fixed_atom(24'h800000, 24'h7FFFFF, 1'b0, 1'b1));
        wait_idle();
        // two axes, counts at their bound, tiny volume, mismatched frame count
        write_reg(REG_DIMENSIONS, 2);
        write_reg(REG_OVERLAP_SQ, 64'h100_0000);
        write_reg(REG_ATOM_COUNT, 65536);
        write_reg(REG_FRAMES, 4096);
        write_reg(REG_VOLUME, 1);
        send_atom(fixed_atom(24'h000000, 24'h000000, 1'b1, 1'b0));
        send_atom(fixed_atom(24'h000000, 24'h000000, 1'b1, 1'b1));
        wait_idle();
        write_reg(REG_ATOM_COUNT, 1);
        write_reg(REG_FRAMES, 1);
        send_atom(fixed_atom(24'h000000, 24'h000000, 1'b1, 1'b0));
        send_atom(fixed_atom(24'h000000, 24'h000000, 1'b1, 1'b0));
        send_atom(fixed_atom(24'h000000, 24'h000000, 1'b1, 1'b1));
        wait_idle();
    endtask

    task automatic test_long_frame();
        // every atom overlaps; one long frame sent back to back
        write_reg(REG_DIMENSIONS, 0);
        write_reg(REG_VOLUME, 64'h10_0000);
        no_gaps = 1'b1;
        for (int i = 0; i < 64; i++)
            send_atom(fixed_atom(24'h000000, 24'h000000, 1'b0, i == 63));
        no_gaps = 1'b0;
        wait_idle();
    endtask

    task automatic random_config();
        write_reg(REG_DIMENSIONS, $urandom_range(0, 5) == 0 ? 0 : $urandom_range(1, 3));
        write_reg(REG_OVERLAP_SQ, $urandom_range(0, 7) == 0 ?
                  {$urandom(), $urandom()} : $urandom_range(0, 1 << 27));
        write_reg(REG_ATOM_COUNT, $urandom_range(0, 12));
        write_reg(REG_FRAMES, $urandom_range(0, 4));
        write_reg(REG_VOLUME, {$urandom(), $urandom()});
    endtask

    task automatic test_random_lags();
        int frames;
        for (int ph = 0; ph < 7; ph++)
        begin
            random_config();
            for (int k = 0; k < 16; k++)
            begin
                frames = (sh_frames != 0 && $urandom_range(0, 3) != 0) ?
                         sh_frames : $urandom_range(1, 4);
                run_lag(frames, $urandom_range(1, 5), $urandom_range(1, 1 << 13));
            end
            wait_idle();
        end
    endtask

    task automatic test_result_backpressure();
        // receiver holds off; the input queue fills and stalls the sender
        hold_left = 3000;
        no_gaps = 1'b1;
        for (int i = 0; i < 40; i++)
            run_lag(1, 2, 1 << 12);
        no_gaps = 1'b0;
        wait_idle();
    endtask

    task automatic test_steady_stream();
        quiet = 1'b1;
        random_config();
        for (int k = 0; k < 30; k++)
            run_lag($urandom_range(1, 3), 4, $urandom_range(1, 1 << 13));
        wait_idle();
    endtask

    initial
    begin
        sh_overlap = 52'd16777216;
        sh_atoms = 1;
        sh_frames = 1;
        sh_volume = 256;
        sh_dims = 3;
        frame_hits = 0;
        hit_sum = 0;
        hit_sq_sum = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_register_extremes();
        test_long_frame();
        test_random_lags();
        test_result_backpressure();
        test_steady_stream();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
